// ----- hdl/gcd_pkg.sv -----
// Shared types, constants and coefficient table for the great-circle distance block.
`default_nettype none
package gcd_pkg;

   localparam logic [63:0] PI_Q62   = 64'hC90F_DAA2_2168_C235;
   localparam logic [63:0] Q62_ONE  = 64'h4000_0000_0000_0000;
   localparam logic [63:0] Q60_ONE  = 64'h1000_0000_0000_0000;
   localparam logic [22:0] RADIUS_RESET = 23'd6371000;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = 2;

   // One queued pair, already in 2^32 units per turn.
   typedef struct packed {
      logic [31:0] lat1;
      logic [31:0] lat2;
      logic [31:0] dlat;
      logic [31:0] dlon;
   } item_type;

   typedef struct packed {
      logic        go;
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic        go;
      logic [63:0] num;
      logic [7:0]  den;
   } div_req_type;

   // Taylor divisors: (2k)(2k+1) for sine, (2k-1)(2k) for cosine.
   function automatic logic [7:0] div_const(input logic [2:0] k, input logic use_cos);
      logic [7:0] d;
      d = 8'd1;
      if (use_cos) begin
         case (k)
            3'd1:    d = 8'd2;
            3'd2:    d = 8'd12;
            3'd3:    d = 8'd30;
            3'd4:    d = 8'd56;
            3'd5:    d = 8'd90;
            3'd6:    d = 8'd132;
            3'd7:    d = 8'd182;
            default: d = 8'd1;
         endcase
      end else begin
         case (k)
            3'd1:    d = 8'd6;
            3'd2:    d = 8'd20;
            3'd3:    d = 8'd42;
            3'd4:    d = 8'd72;
            3'd5:    d = 8'd110;
            3'd6:    d = 8'd156;
            default: d = 8'd1;
         endcase
      end
      return d;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/gcd_mul.sv -----
// Iterative 64x64 multiplier built on one 32x32 multiplier, four partial products.
`default_nettype none
module gcd_mul (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire gcd_pkg::mul_req_type req,
   output logic                     done,
   output logic [127:0]             prod
);
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [1:0]    idx_ff, idx_in;
   logic [63:0]   a_ff, a_in, b_ff, b_in;
   logic [127:0]  acc_ff, acc_in;
   logic [31:0]   a_part, b_part;
   logic [63:0]   pp;
   logic [127:0]  pp_sh;

   always_comb begin
      a_part = idx_ff[0] ? a_ff[63:32] : a_ff[31:0];
      b_part = idx_ff[1] ? b_ff[63:32] : b_ff[31:0];
      pp     = a_part * b_part;
      case ({idx_ff[1], idx_ff[0]})
         2'b00:   pp_sh = {64'b0, pp};
         2'b11:   pp_sh = {pp, 64'b0};
         default: pp_sh = {32'b0, pp, 32'b0};
      endcase
      busy_in = busy_ff;
      done_in = 1'b0;
      idx_in  = idx_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (req.go) begin
         busy_in = 1'b1;
         idx_in  = 2'd0;
         a_in    = req.a;
         b_in    = req.b;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = acc_ff + pp_sh;
         idx_in = idx_ff + 2'd1;
         if (idx_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         idx_ff  <= idx_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;
endmodule
`default_nettype wire

// ----- hdl/gcd_div.sv -----
// Constant divider, 64-bit dividend by 8-bit divisor, by reciprocal multiplication.
`default_nettype none
module gcd_div (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire gcd_pkg::div_req_type req,
   output logic                     done,
   output logic [63:0]              quot
);
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   // The reciprocal is floor((2^64-1)/d), so the high half of the product is
   // the quotient or one below it; one compare against the remainder settles it.
   function automatic logic [63:0] recip(input logic [7:0] d);
      logic [63:0] m;
      case (d)
         8'd2:    m = ALL_ONES / 64'd2;
         8'd6:    m = ALL_ONES / 64'd6;
         8'd12:   m = ALL_ONES / 64'd12;
         8'd20:   m = ALL_ONES / 64'd20;
         8'd30:   m = ALL_ONES / 64'd30;
         8'd42:   m = ALL_ONES / 64'd42;
         8'd56:   m = ALL_ONES / 64'd56;
         8'd72:   m = ALL_ONES / 64'd72;
         8'd90:   m = ALL_ONES / 64'd90;
         8'd110:  m = ALL_ONES / 64'd110;
         8'd132:  m = ALL_ONES / 64'd132;
         8'd156:  m = ALL_ONES / 64'd156;
         8'd182:  m = ALL_ONES / 64'd182;
         default: m = ALL_ONES;
      endcase
      return m;
   endfunction

   gcd_pkg::mul_req_type mreq;
   logic                 mdone;
   logic [127:0]         prod;
   logic                 fix_ff, fix_in;
   logic                 done_ff, done_in;
   logic [63:0]          num_ff, num_in;
   logic [7:0]           den_ff, den_in;
   logic [63:0]          q0_ff, q0_in;
   logic [63:0]          quot_ff, quot_in;
   logic [63:0]          qd, rem;

   gcd_mul u_mul (.clock(clock), .reset(reset), .req(mreq), .done(mdone), .prod(prod));

   always_comb begin
      mreq.go = req.go;
      mreq.a  = req.num;
      mreq.b  = recip(req.den);
      qd      = q0_ff * {56'd0, den_ff};
      rem     = num_ff - qd;
      num_in  = req.go ? req.num : num_ff;
      den_in  = req.go ? req.den : den_ff;
      q0_in   = mdone ? prod[127:64] : q0_ff;
      fix_in  = mdone;
      done_in = fix_ff;
      quot_in = fix_ff ? (q0_ff + {63'd0, (rem >= {56'd0, den_ff})}) : quot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
      num_ff  <= num_in;
      den_ff  <= den_in;
      q0_ff   <= q0_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule
`default_nettype wire

// ----- hdl/gcd_front.sv -----
// Front end: takes a word, brings angles to 2^32 per turn and forms the differences.
`default_nettype none
module gcd_front #(
   parameter int ANGLE_BITS = 32
) (
   input  wire logic              start,
   input  wire logic              full,
   input  wire logic [31:0]       first_lat,
   input  wire logic [31:0]       first_lon,
   input  wire logic [31:0]       second_lat,
   input  wire logic [31:0]       second_lon,
   output logic                   push,
   output gcd_pkg::item_type      item
);
   localparam int SH  = 32 - ANGLE_BITS;
   localparam int SHL = (SH >= 0) ? SH : 0;
   localparam int SHR = (SH < 0) ? -SH : 1;

   function automatic logic [31:0] to_turn32(input logic [31:0] f);
      logic [63:0] v;
      logic [63:0] r;
      v = {{32{f[31]}}, f};
      if (SH >= 0) r = v << SHL;
      else         r = (v + (64'd1 << (SHR - 1))) >> SHR;
      return r[31:0];
   endfunction

   logic [31:0] lat1, lon1, lat2, lon2;

   always_comb begin
      lat1      = to_turn32(first_lat);
      lon1      = to_turn32(first_lon);
      lat2      = to_turn32(second_lat);
      lon2      = to_turn32(second_lon);
      item.lat1 = lat1;
      item.lat2 = lat2;
      item.dlat = lat1 - lat2;
      item.dlon = lon1 - lon2;
      push      = start && !full;
   end
endmodule
`default_nettype wire

// ----- hdl/gcd_queue.sv -----
// Short queue between the front end and the back end.
`default_nettype none
module gcd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire gcd_pkg::item_type push_item,
   input  wire logic              pop,
   output gcd_pkg::item_type      head,
   output logic                   full,
   output logic                   empty
);
   gcd_pkg::item_type entry_ff [gcd_pkg::QUEUE_DEPTH];
   logic [gcd_pkg::QPTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [gcd_pkg::QPTR_BITS:0]   cnt_ff, cnt_in;

   always_comb begin
      full  = (cnt_ff == (gcd_pkg::QPTR_BITS+1)'(gcd_pkg::QUEUE_DEPTH));
      empty = (cnt_ff == '0);
      head  = entry_ff[rd_ff];
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) entry_ff[wr_ff] <= push_item;
   end
endmodule
`default_nettype wire

// ----- hdl/gcd_back.sv -----
// Back end: sequencer that evaluates the haversine with a shared multiplier and divider.
`default_nettype none
module gcd_back #(
   parameter int ANGLE_BITS = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              empty,
   input  wire gcd_pkg::item_type head,
   input  wire logic [22:0]       radius,
   output logic                   pop,
   output logic                   rsp_valid,
   output logic [31:0]            central_angle,
   output logic [24:0]            arc_distance_m
);
   localparam int OSH = ANGLE_BITS - 32;
   localparam int OLS = (OSH > 0) ? OSH : 0;
   localparam int ORS = (OSH < 0) ? -OSH : 1;

   localparam logic [2:0] PH_DLAT = 3'd0;
   localparam logic [2:0] PH_DLON = 3'd1;
   localparam logic [2:0] PH_COS1 = 3'd2;
   localparam logic [2:0] PH_COS2 = 3'd3;
   localparam logic [2:0] PH_BIS  = 3'd4;

   typedef enum logic [15:0] {
      ST_IDLE    = 16'h0001,
      ST_SN_T    = 16'h0002,
      ST_SN_U    = 16'h0004,
      ST_SN_MV   = 16'h0008,
      ST_SN_DV   = 16'h0010,
      ST_SN_FIN  = 16'h0020,
      ST_RET     = 16'h0040,
      ST_HL      = 16'h0080,
      ST_HN      = 16'h0100,
      ST_CC      = 16'h0200,
      ST_TM      = 16'h0400,
      ST_BS_SQ   = 16'h0800,
      ST_BS_NEXT = 16'h1000,
      ST_DR      = 16'h2000,
      ST_DP      = 16'h4000,
      ST_OUT     = 16'h8000
   } state_type;

   state_type          state_ff, state_in;
   logic               issued_ff, issued_in;
   gcd_pkg::item_type  item_ff, item_in;
   logic [2:0]         phase_ff, phase_in;
   logic [32:0]        sarg_ff, sarg_in;
   logic               sneg_ff, sneg_in, usecos_ff, usecos_in;
   logic [63:0]        t_ff, t_in, u_ff, u_in, v_ff, v_in, smag_ff, smag_in;
   logic [2:0]         k_ff, k_in;
   logic [63:0]        sd_ff, sd_in, sl_ff, sl_in, c1_ff, c1_in, c2_ff, c2_in;
   logic               n1_ff, n1_in, n2_ff, n2_in;
   logic [63:0]        hlat_ff, hlat_in, hlon_ff, hlon_in, m_ff, m_in, x_ff, x_in;
   logic [31:0]        lo_ff, lo_in, hi_ff, hi_in, cur_ff, cur_in, h_ff, h_in;
   logic               first_ff, first_in;
   logic [63:0]        rh_ff, rh_in, p_ff, p_in;

   gcd_pkg::mul_req_type mreq;
   gcd_pkg::div_req_type dreq;
   logic                 mdone, ddone;
   logic [127:0]         prod;
   logic [63:0]          quot;

   gcd_mul u_mul (.clock(clock), .reset(reset), .req(mreq), .done(mdone), .prod(prod));
   gcd_div u_div (.clock(clock), .reset(reset), .req(dreq), .done(ddone), .quot(quot));

   logic [31:0]        r31, rq, targ;
   logic               want_cos;
   logic signed [63:0] xs;
   logic               fits;
   logic [31:0]        span, mid;
   logic [63:0]        ang64, dist64;

   always_comb begin
      r31      = {1'b0, sarg_ff[30:0]};
      rq       = sarg_ff[31] ? (32'h8000_0000 - r31) : r31;
      want_cos = (rq > 32'h4000_0000);
      targ     = want_cos ? (32'h8000_0000 - rq) : rq;
      xs       = (n1_ff != n2_ff) ? ($signed(hlat_ff) - $signed(prod[123:60]))
                                  : ($signed(hlat_ff) + $signed(prod[123:60]));
      fits     = (prod[127:64] < x_ff) || (prod[127:64] == x_ff && prod[63:0] == 64'd0);
      span     = hi_ff - lo_ff;
      mid      = lo_ff + (span >> 1);

      state_in  = state_ff;
      issued_in = issued_ff;
      item_in   = item_ff;
      phase_in  = phase_ff;
      sarg_in   = sarg_ff;
      sneg_in   = sneg_ff;
      usecos_in = usecos_ff;
      t_in = t_ff; u_in = u_ff; v_in = v_ff; smag_in = smag_ff; k_in = k_ff;
      sd_in = sd_ff; sl_in = sl_ff; c1_in = c1_ff; c2_in = c2_ff;
      n1_in = n1_ff; n2_in = n2_ff;
      hlat_in = hlat_ff; hlon_in = hlon_ff; m_in = m_ff; x_in = x_ff;
      lo_in = lo_ff; hi_in = hi_ff; cur_in = cur_ff; h_in = h_ff; first_in = first_ff;
      rh_in = rh_ff; p_in = p_ff;
      pop  = 1'b0;
      mreq = '0;
      dreq = '0;

      case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               item_in  = head;
               phase_in = PH_DLAT;
               sarg_in  = {1'b0, head.dlat};
               state_in = ST_SN_T;
            end
         end
         ST_SN_T: begin
            mreq.a = {32'b0, targ};
            mreq.b = gcd_pkg::PI_Q62;
            mreq.go = !issued_ff;
            issued_in = 1'b1;
            if (mdone) begin
               issued_in = 1'b0;
               t_in      = prod[95:32];
               sneg_in   = sarg_ff[32];
               usecos_in = want_cos;
               state_in  = ST_SN_U;
            end
         end
         ST_SN_U: begin
            mreq.a = t_ff;
            mreq.b = t_ff;
            mreq.go = !issued_ff;
            issued_in = 1'b1;
            if (mdone) begin
               issued_in = 1'b0;
               u_in     = prod[125:62];
               v_in     = gcd_pkg::Q62_ONE;
               k_in     = usecos_ff ? 3'd7 : 3'd6;
               state_in = ST_SN_MV;
            end
         end
         ST_SN_MV: begin
            mreq.a = u_ff;
            mreq.b = v_ff;
            mreq.go = !issued_ff;
            issued_in = 1'b1;
            if (mdone) begin
               issued_in = 1'b0;
               v_in     = prod[125:62];
               state_in = ST_SN_DV;
            end
         end
         ST_SN_DV: begin
            dreq.num = v_ff;
            dreq.den = gcd_pkg::div_const(k_ff, usecos_ff);
            dreq.go  = !issued_ff;
            issued_in = 1'b1;
            if (ddone) begin
               issued_in = 1'b0;
               v_in     = gcd_pkg::Q62_ONE - quot;
               k_in     = k_ff - 3'd1;
               state_in = (k_ff == 3'd1) ? ST_SN_FIN : ST_SN_MV;
            end
         end
         ST_SN_FIN: begin
            if (usecos_ff) begin
               smag_in  = v_ff;
               state_in = ST_RET;
            end else begin
               mreq.a = t_ff;
               mreq.b = v_ff;
               mreq.go = !issued_ff;
               issued_in = 1'b1;
               if (mdone) begin
                  issued_in = 1'b0;
                  smag_in  = prod[125:62];
                  state_in = ST_RET;
               end
            end
         end
         ST_RET: begin
            case (phase_ff)
               PH_DLAT: begin
                  sd_in    = smag_ff;
                  sarg_in  = {1'b0, item_ff.dlon};
                  phase_in = PH_DLON;
                  state_in = ST_SN_T;
               end
               PH_DLON: begin
                  sl_in    = smag_ff;
                  sarg_in  = {item_ff.lat1, 1'b0} + 33'h0_8000_0000;
                  phase_in = PH_COS1;
                  state_in = ST_SN_T;
               end
               PH_COS1: begin
                  c1_in    = smag_ff;
                  n1_in    = sneg_ff;
                  sarg_in  = {item_ff.lat2, 1'b0} + 33'h0_8000_0000;
                  phase_in = PH_COS2;
                  state_in = ST_SN_T;
               end
               PH_COS2: begin
                  c2_in    = smag_ff;
                  n2_in    = sneg_ff;
                  state_in = ST_HL;
               end
               default: state_in = ST_BS_SQ;
            endcase
         end
         ST_HL: begin
            mreq.a = sd_ff;
            mreq.b = sd_ff;
            mreq.go = !issued_ff;
            issued_in = 1'b1;
            if (mdone) begin
               issued_in = 1'b0;
               hlat_in  = prod[127:64];
               state_in = ST_HN;
            end
         end
         ST_HN: begin
            mreq.a = sl_ff;
            mreq.b = sl_ff;
            mreq.go = !issued_ff;
            issued_in = 1'b1;
            if (mdone) begin
               issued_in = 1'b0;
               hlon_in  = prod[127:64];
               state_in = ST_CC;
            end
         end
         ST_CC: begin
            mreq.a = c1_ff;
            mreq.b = c2_ff;
            mreq.go = !issued_ff;
            issued_in = 1'b1;
            if (mdone) begin
               issued_in = 1'b0;
               m_in     = prod[127:64];
               state_in = ST_TM;
            end
         end
         ST_TM: begin
            mreq.a = m_ff;
            mreq.b = hlon_ff;
            mreq.go = !issued_ff;
            issued_in = 1'b1;
            if (mdone) begin
               issued_in = 1'b0;
               if (xs < 64'sd0)                          x_in = 64'd0;
               else if (xs > $signed(gcd_pkg::Q60_ONE))  x_in = gcd_pkg::Q60_ONE;
               else                                      x_in = xs;
               first_in = 1'b1;
               cur_in   = 32'h8000_0000;
               sarg_in  = {1'b0, 32'h8000_0000};
               phase_in = PH_BIS;
               state_in = ST_SN_T;
            end
         end
         ST_BS_SQ: begin
            mreq.a = smag_ff;
            mreq.b = smag_ff;
            mreq.go = !issued_ff;
            issued_in = 1'b1;
            if (mdone) begin
               issued_in = 1'b0;
               if (first_ff) begin
                  if (fits) begin
                     h_in     = 32'h8000_0000;
                     state_in = ST_DR;
                  end else begin
                     lo_in    = 32'd0;
                     hi_in    = 32'h8000_0000;
                     state_in = ST_BS_NEXT;
                  end
               end else begin
                  if (fits) lo_in = cur_ff;
                  else      hi_in = cur_ff;
                  state_in = ST_BS_NEXT;
               end
            end
         end
         ST_BS_NEXT: begin
            first_in = 1'b0;
            if (span > 32'd1) begin
               cur_in   = mid;
               sarg_in  = {1'b0, mid};
               state_in = ST_SN_T;
            end else begin
               h_in     = lo_ff;
               state_in = ST_DR;
            end
         end
         ST_DR: begin
            mreq.a = {41'b0, radius};
            mreq.b = {32'b0, h_ff};
            mreq.go = !issued_ff;
            issued_in = 1'b1;
            if (mdone) begin
               issued_in = 1'b0;
               rh_in    = prod[63:0];
               state_in = ST_DP;
            end
         end
         ST_DP: begin
            mreq.a = rh_ff;
            mreq.b = gcd_pkg::PI_Q62;
            mreq.go = !issued_ff;
            issued_in = 1'b1;
            if (mdone) begin
               issued_in = 1'b0;
               p_in     = prod[127:64];
               state_in = ST_OUT;
            end
         end
         ST_OUT:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase

      if (OSH == 0) begin
         ang64 = {32'b0, h_ff};
      end else if (OSH < 0) begin
         ang64 = ({32'b0, h_ff} + (64'd1 << (ORS - 1))) >> ORS;
      end else begin
         ang64 = {32'b0, h_ff} << OLS;
         if (ang64 > 64'h0000_0000_FFFF_FFFF) ang64 = 64'h0000_0000_FFFF_FFFF;
      end
      dist64         = (p_ff + (64'd1 << 28)) >> 29;
      central_angle  = ang64[31:0];
      arc_distance_m = dist64[24:0];
      rsp_valid      = (state_ff == ST_OUT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         issued_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
      end
      item_ff <= item_in;   phase_ff <= phase_in;   sarg_ff <= sarg_in;
      sneg_ff <= sneg_in;   usecos_ff <= usecos_in;
      t_ff <= t_in;   u_ff <= u_in;   v_ff <= v_in;   smag_ff <= smag_in;   k_ff <= k_in;
      sd_ff <= sd_in; sl_ff <= sl_in; c1_ff <= c1_in; c2_ff <= c2_in;
      n1_ff <= n1_in; n2_ff <= n2_in;
      hlat_ff <= hlat_in; hlon_ff <= hlon_in; m_ff <= m_in; x_ff <= x_in;
      lo_ff <= lo_in; hi_ff <= hi_in; cur_ff <= cur_in; h_ff <= h_in; first_ff <= first_in;
      rh_ff <= rh_in; p_ff <= p_in;
   end
endmodule
`default_nettype wire

// ----- hdl/great_circle_distance.sv -----
// Top level of the haversine great-circle distance block.
//
//   Channel   Ports                                   Handshake
//   request   req_first_lat/lon, req_second_lat/lon   start, busy
//   response  rsp_central_angle, rsp_arc_distance_m   rsp_valid (one-cycle strobe)
//   control   csr_sphere_radius_m                     csr_valid, csr_ready
//
// A request word is taken at a clock edge with start high and busy low. The front
// end converts it and places it in a four-entry queue, so up to four words are
// taken while the back end is still working. The back end takes one word at a
// time: each sine is computed on the shared 64-bit multiplier and the reciprocal
// constant divider, and the bisection for the arcsine evaluates up to 32 of them.
// Reset is synchronous and empties the queue. The receiver cannot stall; each
// result shows for exactly one cycle.
`default_nettype none
module great_circle_distance #(
   parameter int ANGLE_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_first_lat,
   input  wire logic [31:0] req_first_lon,
   input  wire logic [31:0] req_second_lat,
   input  wire logic [31:0] req_second_lon,
   output logic             rsp_valid,
   output logic [31:0]      rsp_central_angle,
   output logic [24:0]      rsp_arc_distance_m,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [22:0] csr_sphere_radius_m
);
   // Sphere radius register; the user must write it only while no word is in flight, the block does not enforce it.
   logic [22:0] radius_ff, radius_in;

   gcd_pkg::item_type front_item, head;
   logic              push, pop, full, empty;

   assign csr_ready = 1'b1;
   assign radius_in = (csr_valid && csr_ready) ? csr_sphere_radius_m : radius_ff;
   assign busy      = full;

   always_ff @(posedge clock) begin
      if (reset) radius_ff <= gcd_pkg::RADIUS_RESET;
      else       radius_ff <= radius_in;
   end

   // Front end: angle conversion and the two differences.
   gcd_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
      .start(start), .full(full),
      .first_lat(req_first_lat), .first_lon(req_first_lon),
      .second_lat(req_second_lat), .second_lon(req_second_lon),
      .push(push), .item(front_item)
   );

   // Queue that lets the front keep taking words while the back end works.
   gcd_queue u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_item(front_item),
      .pop(pop), .head(head), .full(full), .empty(empty)
   );

   // Back end: sines, haversine sum, arcsine by bisection and distance scaling.
   gcd_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
      .clock(clock), .reset(reset),
      .empty(empty), .head(head), .radius(radius_ff), .pop(pop),
      .rsp_valid(rsp_valid), .central_angle(rsp_central_angle),
      .arc_distance_m(rsp_arc_distance_m)
   );
endmodule
`default_nettype wire

// ----- hdl/gcd_checker.sv -----
// Port-level checks for the great-circle distance block and their binding.
`default_nettype none
module gcd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [24:0] rsp_arc_distance_m,
   input wire logic        csr_valid,
   input wire logic        csr_ready
);
   // The queue is empty right after reset, so a word can be taken right then.
   a_idle_after_reset: assert property (@(posedge clock) $past(reset) |-> !busy)
      else $error("busy high right after reset");

   // No two results come in consecutive cycles.
   a_strobe_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in consecutive cycles");

   // No result in the cycle after reset.
   a_no_rsp_after_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");

   // The largest radius times pi bounds every distance.
   a_dist_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_arc_distance_m <= 25'd26353589)
      else $error("distance out of range");
endmodule

bind great_circle_distance gcd_checker u_gcd_checker (.*);
`default_nettype wire
